### rtl/fmdd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and address-map helpers for the FM register write filter.
// No dependencies.
package fmdd_pkg;

  localparam int unsigned TableDepth = 512;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned EntryW     = 9;

  // Bit 8 set marks an entry whose register value is not known
  localparam logic [EntryW-1:0] UNKNOWN_ENTRY = 9'h100;

  localparam logic [1:0] MODE_KEEP_ALL   = 2'd0;
  localparam logic [1:0] MODE_DEDUP      = 2'd1;
  localparam logic [1:0] MODE_DEDUP_FREQ = 2'd2;
  localparam logic [1:0] MODE_RESET      = MODE_DEDUP;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PASS  = 2'd1,
    OP_LOOP  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_PAIR,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [EntryW-1:0] wdata;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic keep;
    logic addr_valid;
  } result_t;

  function automatic logic addr_is_valid(input logic port, input logic [7:0] a);
    logic ok;
    ok = 1'b0;
    if (a inside {8'h22, 8'h27, 8'h28, 8'h2A, 8'h2B}) begin
      ok = !port;
    end else if (a inside {[8'h30:8'hB7]}) begin
      if (port && (a inside {[8'hA8:8'hAF]})) begin
        ok = 1'b0;
      end else begin
        ok = (a[1:0] != 2'b11);
      end
    end
    return ok;
  endfunction

  function automatic logic is_freq(input logic [AddrW-1:0] m);
    return (m[7:4] == 4'hA);
  endfunction

  // High byte of a frequency pair: mapped address matches xxA4 under mask 0xF4
  function automatic logic is_freq_high(input logic [AddrW-1:0] m);
    return (m[7:4] == 4'hA) && m[2];
  endfunction

endpackage

### rtl/fmdd_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Depends on fmdd_pkg for default sizes.
module fmdd_ram
  import fmdd_pkg::*;
#(
  parameter int unsigned Depth = TableDepth,
  parameter int unsigned Width = EntryW
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/fmdd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the write filter: address check, shadow read-modify-write,
// start-pass and loop-found sweeps, and the clearing pass after reset. Uses fmdd_pkg.
module fmdd_ctrl
  import fmdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic              in_port,
  input  logic [7:0]        in_addr,
  input  logic [7:0]        in_data,
  input  logic              out_free,
  output result_t           res,
  output mem_req_t          sh_req,
  output mem_req_t          sn_req,
  input  logic [EntryW-1:0] sh_rd,
  input  logic [EntryW-1:0] sn_rd
);

  state_t            state, state_next;
  logic [CntW-1:0]   cnt, cnt_next;
  logic              pend, pend_next;
  logic [AddrW-1:0]  paddr, paddr_next;
  logic [1:0]        mode;
  op_t               op_q;
  logic [AddrW-1:0]  wr_addr;
  logic [7:0]        wr_data;
  logic              wr_av;
  logic              res_keep, res_keep_next;
  logic              res_av, res_av_next;
  logic              differ;
  logic              keep_c;
  logic              pair_c;
  logic              store_c;
  logic              accept;

  assign accept = in_valid && in_ready;
  assign differ = (sh_rd != {1'b0, wr_data});

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      pend     <= 1'b0;
      mode     <= MODE_RESET;
      res_keep <= 1'b0;
      res_av   <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      pend     <= pend_next;
      res_keep <= res_keep_next;
      res_av   <= res_av_next;
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
    end
  end

  // Item payload, captured at acceptance
  always_ff @(posedge clk) begin
    paddr <= paddr_next;
    if (accept) begin
      op_q    <= op_t'(in_op);
      wr_addr <= {in_port, in_addr};
      wr_data <= in_data;
      wr_av   <= addr_is_valid(in_port, in_addr);
    end
  end

  // Decision on the shadow entry read for a write
  always_comb begin
    keep_c  = 1'b0;
    pair_c  = 1'b0;
    store_c = 1'b0;
    if (mode == MODE_KEEP_ALL) begin
      keep_c = 1'b1;
    end else if (wr_av) begin
      if (!is_freq(wr_addr)) begin
        store_c = differ;
        keep_c  = differ;
      end else if (mode == MODE_DEDUP_FREQ) begin
        store_c = differ;
        keep_c  = differ;
        pair_c  = differ && is_freq_high(wr_addr);
      end else begin
        keep_c = 1'b1;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    pend_next     = 1'b0;
    paddr_next    = cnt[AddrW-1:0];
    res_keep_next = res_keep;
    res_av_next   = res_av;
    in_ready      = 1'b0;
    res           = '0;
    sh_req        = '{we: 1'b0, waddr: paddr, wdata: UNKNOWN_ENTRY, raddr: cnt[AddrW-1:0]};
    sn_req        = '{we: 1'b0, waddr: paddr, wdata: sh_rd, raddr: cnt[AddrW-1:0]};

    case (state)
      ST_INIT: begin
        // Clearing pass: mark both tables unknown, one entry a cycle
        sh_req.we    = 1'b1;
        sh_req.waddr = cnt[AddrW-1:0];
        sn_req.we    = 1'b1;
        sn_req.waddr = cnt[AddrW-1:0];
        sn_req.wdata = UNKNOWN_ENTRY;
        cnt_next     = cnt + 1'b1;
        if (cnt[AddrW-1:0] == AddrW'(TableDepth - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready     = 1'b1;
        sh_req.raddr = {in_port, in_addr};
        if (in_valid) begin
          cnt_next      = '0;
          res_keep_next = 1'b0;
          res_av_next   = 1'b0;
          case (in_op)
            OP_WRITE:        state_next = ST_CHECK;
            OP_PASS, OP_LOOP: state_next = ST_SWEEP;
            default:         state_next = ST_DONE;
          endcase
        end
      end

      ST_CHECK: begin
        sh_req.we     = store_c;
        sh_req.waddr  = wr_addr;
        sh_req.wdata  = {1'b0, wr_data};
        res_keep_next = keep_c;
        res_av_next   = wr_av;
        if (pair_c) begin
          state_next = ST_PAIR;
        end else if (out_free) begin
          res        = '{valid: 1'b1, keep: keep_c, addr_valid: wr_av};
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_PAIR: begin
        // Forget the low byte paired with the high byte just written
        sh_req.we    = 1'b1;
        sh_req.waddr = {wr_addr[AddrW-1:3], 1'b0, wr_addr[1:0]};
        if (out_free) begin
          res        = '{valid: 1'b1, keep: res_keep, addr_valid: res_av};
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_SWEEP: begin
        // Read entry cnt, write back entry paddr in the following cycle
        if (!cnt[AddrW]) begin
          cnt_next   = cnt + 1'b1;
          pend_next  = 1'b1;
          paddr_next = cnt[AddrW-1:0];
        end
        if (pend) begin
          if (op_q == OP_PASS) begin
            sn_req.we = 1'b1;
            sh_req.we = 1'b1;
          end else begin
            sh_req.we = (sh_rd != sn_rd) || is_freq(paddr);
          end
        end
        if (cnt[AddrW] && !pend) begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          res        = '{valid: 1'b1, keep: res_keep, addr_valid: res_av};
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

### rtl/fm_register_write_dedup.sv
`timescale 1ns / 1ps
// Redundant register-write filter for a two-port FM sound chip: top level.
// Instantiates fmdd_ctrl and two fmdd_ram tables; uses fmdd_pkg.
//
// Usage:
//   Slave channel s_*: one beat per operation. s_tuser is the operation
//   (write, start pass, loop found); s_tdata carries port, register address
//   and data. Master channel m_*: exactly one result beat per input beat,
//   with keep and address_valid.
//   cfg_wr_en/cfg_wr_data write the mode register; write it only while idle.
//
// Timing: the accepting edge issues the shadow-RAM read; the next cycle writes
// back and loads the result into the output register. A changed frequency high
// byte in mode 2 adds the ST_PAIR state to forget its paired low byte. Start pass
// and loop found walk all 512 entries in ST_SWEEP before their result is loaded.
// One operation at a time.
// Reset: after rst falls, a clearing pass marks both tables unknown; s_tready
// stays low for its duration. The mode resets to 1.
// Stall: the result sits in an output register; while it is held with m_tready low,
// a finished operation waits in ST_DONE and no further beat is taken.
module fm_register_write_dedup
  import fmdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [0] port, [8:1] reg_address, [16:9] reg_data, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] keep, [1] address_valid, rest zero
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  result_t           res;
  mem_req_t          sh_req;
  mem_req_t          sn_req;
  logic [EntryW-1:0] sh_rd;
  logic [EntryW-1:0] sn_rd;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  fmdd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser),
    .in_port    (s_tdata[0]),
    .in_addr    (s_tdata[8:1]),
    .in_data    (s_tdata[16:9]),
    .out_free   (out_free),
    .res        (res),
    .sh_req     (sh_req),
    .sn_req     (sn_req),
    .sh_rd      (sh_rd),
    .sn_rd      (sn_rd)
  );

  fmdd_ram #(
    .Depth(TableDepth),
    .Width(EntryW)
  ) u_shadow (
    .clk  (clk),
    .we   (sh_req.we),
    .waddr(sh_req.waddr),
    .wdata(sh_req.wdata),
    .raddr(sh_req.raddr),
    .rdata(sh_rd)
  );

  fmdd_ram #(
    .Depth(TableDepth),
    .Width(EntryW)
  ) u_snapshot (
    .clk  (clk),
    .we   (sn_req.we),
    .waddr(sn_req.waddr),
    .wdata(sn_req.wdata),
    .raddr(sn_req.raddr),
    .rdata(sn_rd)
  );

  // Output register: load a result, drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= {6'b0, res.addr_valid, res.keep};
    end
  end

endmodule

### rtl/fmdd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for fm_register_write_dedup, attached by bind.
// No dependencies.
module fmdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // Held result beat stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:2] == 6'b0))
    else $error("result padding bits not zero");

  // One operation in flight: no beat taken in the cycle after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("beat accepted while an operation is in flight");

  // Clearing pass after reset blocks input
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_tready)
    else $error("input ready during clearing pass");

endmodule

bind fm_register_write_dedup fmdd_checker u_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for fm_register_write_dedup: directed and random register
// writes, start-pass and loop-found beats, checked against an in-bench shadow-table model.
// Depends on fmdd_pkg and the fm_register_write_dedup RTL.
module testbench;
  import fmdd_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [1:0] MODE_FALLBACK = 2'd3;

  typedef struct packed {
    logic keep;
    logic addr_ok;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;

  // Predicted register state
  logic [8:0] shadow_img [TableDepth];
  logic [8:0] snap_img [TableDepth];
  logic [1:0] mode_now;

  verdict_t pending_verdicts[$];
  int       err_count = 0;

  // Sender and receiver pacing
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int burst_left = 0;
  int stall_left = 0;

  // Last write sent, reused to provoke duplicates
  logic       last_port = 1'b0;
  logic [7:0] last_addr = 8'h30;
  logic [7:0] last_data = 8'h00;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fm_register_write_dedup u_top (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic logic reg_in_map(input logic port, input logic [7:0] a);
    case (a)
      8'h22, 8'h27, 8'h28, 8'h2A, 8'h2B: return !port;
      default: ;
    endcase
    if (a < 8'h30 || a > 8'hB7 || a[1:0] == 2'b11) return 1'b0;
    // port 1 has no A8..AF block
    if (port && a[7:3] == 5'b10101) return 1'b0;
    return 1'b1;
  endfunction

  function automatic verdict_t filter_step(input logic [1:0] op, input logic port,
                                           input logic [7:0] a, input logic [7:0] d);
    verdict_t   v;
    logic [8:0] m;
    logic       freq;
    v = '0;
    m = {port, a};
    freq = (m[7:4] == 4'hA);
    case (op)
      OP_WRITE: begin
        v.addr_ok = reg_in_map(port, a);
        if (mode_now == MODE_KEEP_ALL) begin
          v.keep = 1'b1;
        end else if (v.addr_ok) begin
          if (freq && mode_now != MODE_DEDUP_FREQ) begin
            v.keep = 1'b1;
          end else if (shadow_img[m] != {1'b0, d}) begin
            shadow_img[m] = {1'b0, d};
            // a changed high byte makes its low byte unknown
            if (freq && m[2]) shadow_img[m - 9'd4] = UNKNOWN_ENTRY;
            v.keep = 1'b1;
          end
        end
      end
      OP_PASS: begin
        snap_img = shadow_img;
        foreach (shadow_img[i]) shadow_img[i] = UNKNOWN_ENTRY;
      end
      OP_LOOP: begin
        foreach (shadow_img[i]) begin
          if (shadow_img[i] != snap_img[i] || i[7:4] == 4'hA) shadow_img[i] = UNKNOWN_ENTRY;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // Result checker and receiver stall pattern
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result beat, actual keep=%0b address_valid=%0b",
                   $time, m_tdata[0], m_tdata[1]);
          err_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata[0] !== want.keep) begin
            $display("%0t: keep mismatch, expected %0b actual %0b",
                     $time, want.keep, m_tdata[0]);
            err_count++;
          end
          if (m_tdata[1] !== want.addr_ok) begin
            $display("%0t: address_valid mismatch, expected %0b actual %0b",
                     $time, want.addr_ok, m_tdata[1]);
            err_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Drive one beat, wait for acceptance, record its expected result
  task automatic send_beat(input logic [1:0] op, input logic port,
                           input logic [7:0] a, input logic [7:0] d);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, d, a, port};
    do @(posedge clk); while (!s_tready);
    pending_verdicts.push_back(filter_step(op, port, a, d));
    if (tx_idle_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 7);
        burst_left = $urandom_range(1, 16);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_now = m;
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_addr();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 8'hA0 + 8'($urandom_range(0, 15));
    if (sel < 45) begin
      case ($urandom_range(0, 4))
        0: return 8'h22;
        1: return 8'h27;
        2: return 8'h28;
        3: return 8'h2A;
        default: return 8'h2B;
      endcase
    end
    if (sel < 65) return 8'($urandom_range(8'h30, 8'h3F));
    if (sel < 85) return 8'($urandom_range(8'h30, 8'hB7));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_write();
    if ($urandom_range(0, 4) != 0) begin
      last_port = 1'($urandom_range(0, 1));
      last_addr = pick_addr();
      last_data = pick_data();
    end
    send_beat(OP_WRITE, last_port, last_addr, last_data);
  endtask

  task automatic test_default_mode();
    send_beat(OP_WRITE, 1'b0, 8'h30, 8'h00);
    send_beat(OP_WRITE, 1'b0, 8'h30, 8'h00);
    send_beat(OP_WRITE, 1'b0, 8'hA0, 8'h12);
    send_beat(OP_WRITE, 1'b0, 8'hA0, 8'h12);
  endtask

  task automatic test_address_map();
    send_beat(OP_WRITE, 1'b0, 8'h22, 8'hFF);
    send_beat(OP_WRITE, 1'b1, 8'h22, 8'hFF);
    send_beat(OP_WRITE, 1'b0, 8'h33, 8'h5A);
    send_beat(OP_WRITE, 1'b0, 8'hB7, 8'h00);
    send_beat(OP_WRITE, 1'b0, 8'hB8, 8'hA5);
    send_beat(OP_WRITE, 1'b1, 8'hAF, 8'h01);
    send_beat(OP_WRITE, 1'b1, 8'hB4, 8'h80);
    send_beat(OP_WRITE, 1'b1, 8'hFF, 8'hFF);
  endtask

  task automatic test_keep_all();
    set_mode(MODE_KEEP_ALL);
    send_beat(OP_WRITE, 1'b0, 8'h00, 8'h00);
    send_beat(OP_WRITE, 1'b0, 8'h30, 8'h00);
  endtask

  task automatic test_freq_pairs();
    set_mode(MODE_DEDUP_FREQ);
    send_beat(OP_WRITE, 1'b1, 8'hA0, 8'h11);
    send_beat(OP_WRITE, 1'b1, 8'hA0, 8'h11);
    send_beat(OP_WRITE, 1'b1, 8'hA4, 8'h22);
    send_beat(OP_WRITE, 1'b1, 8'hA0, 8'h11);
    send_beat(OP_WRITE, 1'b1, 8'hA4, 8'h22);
  endtask

  task automatic test_fallback_mode();
    set_mode(MODE_FALLBACK);
    send_beat(OP_WRITE, 1'b0, 8'hA1, 8'h33);
    send_beat(OP_WRITE, 1'b0, 8'hA1, 8'h33);
    send_beat(OP_WRITE, 1'b0, 8'h31, 8'h44);
    send_beat(OP_WRITE, 1'b0, 8'h31, 8'h44);
  endtask

  task automatic test_pass_loop();
    set_mode(MODE_DEDUP);
    send_beat(OP_WRITE, 1'b0, 8'h34, 8'h05);
    send_beat(OP_WRITE, 1'b0, 8'h35, 8'h06);
    send_beat(OP_PASS, 1'b0, 8'h00, 8'h00);
    send_beat(OP_WRITE, 1'b0, 8'h34, 8'h05);
    send_beat(OP_WRITE, 1'b0, 8'h35, 8'h07);
    send_beat(OP_LOOP, 1'b1, 8'hFF, 8'hFF);
    send_beat(OP_WRITE, 1'b0, 8'h34, 8'h05);
    send_beat(OP_WRITE, 1'b0, 8'h35, 8'h07);
    send_beat(OP_UNUSED, 1'b1, 8'hFF, 8'hFF);
  endtask

  // Play a frame, start a pass, replay it partly changed, find the loop, replay again
  task automatic loop_playback();
    logic       fp [12];
    logic [7:0] fa [12];
    logic [7:0] fd [12];
    foreach (fa[i]) begin
      fp[i] = 1'($urandom_range(0, 1));
      fa[i] = pick_addr();
      fd[i] = pick_data();
      send_beat(OP_WRITE, fp[i], fa[i], fd[i]);
    end
    send_beat(OP_PASS, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
    foreach (fa[i]) begin
      if ($urandom_range(0, 3) == 0) fd[i] = pick_data();
      send_beat(OP_WRITE, fp[i], fa[i], fd[i]);
    end
    send_beat(OP_LOOP, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
    foreach (fa[i]) send_beat(OP_WRITE, fp[i], fa[i], fd[i]);
  endtask

  task automatic test_random_traffic();
    logic [1:0] phase_modes [6];
    int         r;
    phase_modes = '{MODE_DEDUP_FREQ, MODE_KEEP_ALL, MODE_DEDUP, MODE_FALLBACK,
                    MODE_DEDUP_FREQ, MODE_DEDUP};
    foreach (phase_modes[p]) begin
      set_mode(phase_modes[p]);
      // one phase runs flat out on both sides
      tx_idle_on = (p != 2);
      rx_idle_on = (p != 2);
      for (int n = 0; n < 210; n++) begin
        r = $urandom_range(0, 199);
        if (r < 2) begin
          send_beat(OP_PASS, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
        end else if (r < 4) begin
          send_beat(OP_LOOP, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
        end else if (r == 4) begin
          send_beat(OP_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
        end else begin
          random_write();
        end
        if (n % 120 == 60) loop_playback();
      end
    end
  endtask

  initial begin
    foreach (shadow_img[i]) begin
      shadow_img[i] = UNKNOWN_ENTRY;
      snap_img[i]   = UNKNOWN_ENTRY;
    end
    mode_now = MODE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_mode();
    test_address_map();
    test_keep_all();
    test_freq_pairs();
    test_fallback_mode();
    test_pass_loop();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
